[src/tsrd_pkg.sv]
package tsrd_pkg;

	localparam int SYM_W     = 8;
	localparam int FRAMES_W  = 8;
	localparam int ENTRIES_W = 6;
	localparam int MARGIN_W  = 16;
	localparam int INDEX_W   = 5;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int COUNT_W   = 9;

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH    = 3'd4;

	localparam logic [FRAMES_W-1:0]  FRAMES_RST  = 8'd4;
	localparam logic [MARGIN_W-1:0]  TOL_RST     = 16'd304;
	localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 6'd32;
	localparam logic [MARGIN_W-1:0]  LOW_RST     = 16'd640;
	localparam logic [MARGIN_W-1:0]  HIGH_RST    = 16'd4800;

	localparam logic [FRAMES_W-1:0]  FRAMES_MAX  = 8'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic             done;
		logic [SYM_W-1:0] symbol;
	} match_res_t;

endpackage

[src/tsrd_table.sv]
module tsrd_table #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 28,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/tsrd_match.sv]
module tsrd_match #(
	parameter int TABLE_DEPTH = 32,
	parameter int PITCH_BITS = 20,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [PITCH_BITS-1:0]         pitch,
	input  logic [AW-1:0]                 last_idx,
	input  logic [tsrd_pkg::MARGIN_W-1:0] low_margin,
	input  logic [tsrd_pkg::MARGIN_W-1:0] high_margin,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [PITCH_BITS-1:0]         rd_freq,
	input  logic [tsrd_pkg::SYM_W-1:0]    rd_symbol,
	output tsrd_pkg::match_res_t          res
);

	logic                       busy_q;
	logic                       issue_q;
	logic [AW-1:0]              addr_q;
	logic                       vld_s1;
	logic [AW-1:0]              idx_s1;
	logic [PITCH_BITS-1:0]      prev_freq_q;
	logic [tsrd_pkg::SYM_W-1:0] prev_sym_q;
	tsrd_pkg::match_res_t       res_q;

	logic [PITCH_BITS:0]        p_x;
	logic [PITCH_BITS:0]        f_x;
	logic [PITCH_BITS:0]        prev_x;
	logic [PITCH_BITS:0]        low_x;
	logic [PITCH_BITS:0]        high_x;
	logic                       first_hit;
	logic                       pair_hit;
	logic                       near_lo;
	logic                       last_hit;
	logic                       step_done;
	logic [tsrd_pkg::SYM_W-1:0] step_sym;

	assign p_x    = (PITCH_BITS+1)'(pitch);
	assign f_x    = (PITCH_BITS+1)'(rd_freq);
	assign prev_x = (PITCH_BITS+1)'(prev_freq_q);
	assign low_x  = (PITCH_BITS+1)'(low_margin);
	assign high_x = (PITCH_BITS+1)'(high_margin);

	assign first_hit = (p_x + low_x > f_x) && (p_x <= f_x);
	assign pair_hit  = (prev_x < p_x) && (p_x <= f_x);
	assign near_lo   = (f_x - p_x) > (p_x - prev_x);
	assign last_hit  = (f_x < p_x) && (p_x < f_x + high_x);

	// first entry, then ascending pairs, then the window above the last entry
	always_comb begin
		step_done = 1'b0;
		step_sym  = rd_symbol;
		if (idx_s1 == '0 && first_hit) begin
			step_done = 1'b1;
		end else if (idx_s1 != '0 && pair_hit) begin
			step_done = 1'b1;
			step_sym  = near_lo ? prev_sym_q : rd_symbol;
		end else if (idx_s1 == last_idx) begin
			step_done = 1'b1;
			step_sym  = last_hit ? rd_symbol : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			res_q   <= '0;
		end else begin
			vld_s1     <= issue_q;
			idx_s1     <= addr_q;
			res_q.done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				addr_q  <= '0;
			end else begin
				if (issue_q) begin
					if (addr_q == last_idx) begin
						issue_q <= 1'b0;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				if (busy_q && vld_s1 && step_done) begin
					busy_q       <= 1'b0;
					issue_q      <= 1'b0;
					res_q.done   <= 1'b1;
					res_q.symbol <= step_sym;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && vld_s1) begin
			prev_freq_q <= rd_freq;
			prev_sym_q  <= rd_symbol;
		end
	end

	assign rd_en   = issue_q;
	assign rd_addr = addr_q;
	assign res     = res_q;

endmodule

[src/tone_symbol_run_decoder.sv]
// frame beat with nonzero pitch: input stays not ready while the walk steps through entries from 0
// up to k, the entry where it settles (k < n, n = active_entries clamped to 1..TABLE_DEPTH)
// and through the commit; one table read per cycle; an emitting frame also waits while
// the last symbol is held; a symbol is registered onto the output as its frame commits
// load, clear, zero pitch and unused op beats are taken without leaving the idle state
// reset: registers to defaults, candidate cleared; tone table contents are not reset
module tone_symbol_run_decoder #(
	parameter int TABLE_DEPTH = 32,
	parameter int PITCH_BITS = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsrd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsrd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     op,
	input  logic [PITCH_BITS-1:0]          pitch,
	input  logic [tsrd_pkg::INDEX_W-1:0]   entry_index,
	input  logic [PITCH_BITS-1:0]          entry_freq,
	input  logic [tsrd_pkg::SYM_W-1:0]     entry_symbol,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tsrd_pkg::SYM_W-1:0]     symbol
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int TW = PITCH_BITS + tsrd_pkg::SYM_W;

	tsrd_pkg::state_t state_q;
	tsrd_pkg::state_t state_d;

	logic [tsrd_pkg::FRAMES_W-1:0]  frames_q;
	logic [tsrd_pkg::MARGIN_W-1:0]  tol_q;
	logic [tsrd_pkg::ENTRIES_W-1:0] entries_q;
	logic [tsrd_pkg::MARGIN_W-1:0]  low_q;
	logic [tsrd_pkg::MARGIN_W-1:0]  high_q;

	logic [PITCH_BITS-1:0]          cand_freq_q;
	logic [tsrd_pkg::FRAMES_W-1:0]  cand_frames_q;
	logic [tsrd_pkg::SYM_W-1:0]     cand_symbol_q;

	logic [PITCH_BITS-1:0]          p_q;
	logic                           stable_q;
	logic                           fresh_q;
	logic [tsrd_pkg::SYM_W-1:0]     lut_q;
	logic                           out_valid_q;
	logic [tsrd_pkg::SYM_W-1:0]     symbol_q;

	logic                           accept;
	logic                           frame_go;
	logic                           start;
	logic                           commit;
	logic                           can_go;
	logic [PITCH_BITS-1:0]          diff;
	logic                           stable;
	logic [tsrd_pkg::COUNT_W-1:0]   n_eff;
	logic [AW-1:0]                  last_idx;
	logic                           tbl_we;
	logic [TW-1:0]                  rd_word;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	tsrd_pkg::match_res_t           res;
	logic [tsrd_pkg::FRAMES_W-1:0]  new_frames;
	logic                           emit;
	logic [tsrd_pkg::SYM_W-1:0]     emit_sym;

	assign accept   = in_valid && in_ready;
	assign frame_go = accept && (op == tsrd_pkg::OP_FRAME) && (pitch != '0);
	assign tbl_we   = accept && (op == tsrd_pkg::OP_LOAD)
		&& (tsrd_pkg::COUNT_W'(entry_index) < tsrd_pkg::COUNT_W'(TABLE_DEPTH));

	assign diff   = (pitch > cand_freq_q) ? pitch - cand_freq_q : cand_freq_q - pitch;
	assign stable = (cand_freq_q != '0) && (diff < PITCH_BITS'(tol_q));

	always_comb begin
		if (entries_q == '0) begin
			n_eff = tsrd_pkg::COUNT_W'(1);
		end else if (tsrd_pkg::COUNT_W'(entries_q) > tsrd_pkg::COUNT_W'(TABLE_DEPTH)) begin
			n_eff = tsrd_pkg::COUNT_W'(TABLE_DEPTH);
		end else begin
			n_eff = tsrd_pkg::COUNT_W'(entries_q);
		end
	end

	assign last_idx = AW'(n_eff - tsrd_pkg::COUNT_W'(1));

	tsrd_table #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(TW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(entry_index)),
		.wdata ({entry_freq, entry_symbol}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	tsrd_match #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PITCH_BITS(PITCH_BITS)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.pitch       (p_q),
		.last_idx    (last_idx),
		.low_margin  (low_q),
		.high_margin (high_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_freq     (rd_word[TW-1:tsrd_pkg::SYM_W]),
		.rd_symbol   (rd_word[tsrd_pkg::SYM_W-1:0]),
		.res         (res)
	);

	always_comb begin
		if (!stable_q) begin
			new_frames = tsrd_pkg::FRAMES_W'(1);
		end else if (cand_frames_q == tsrd_pkg::FRAMES_MAX) begin
			new_frames = tsrd_pkg::FRAMES_MAX;
		end else begin
			new_frames = cand_frames_q + 1'b1;
		end
	end

	assign emit     = !fresh_q && (new_frames == frames_q);
	assign emit_sym = stable_q ? cand_symbol_q : lut_q;
	assign can_go   = !emit || !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsrd_pkg::ST_IDLE: begin
				if (frame_go) begin
					state_d = tsrd_pkg::ST_WALK;
				end
			end
			tsrd_pkg::ST_WALK: begin
				if (res.done) begin
					state_d = tsrd_pkg::ST_COMMIT;
				end
			end
			tsrd_pkg::ST_COMMIT: begin
				if (can_go) begin
					state_d = tsrd_pkg::ST_IDLE;
				end
			end
			default: state_d = tsrd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		start    = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			tsrd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				start    = frame_go;
			end
			tsrd_pkg::ST_WALK: begin
			end
			tsrd_pkg::ST_COMMIT: begin
				commit = can_go;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tsrd_pkg::ST_IDLE;
			frames_q      <= tsrd_pkg::FRAMES_RST;
			tol_q         <= tsrd_pkg::TOL_RST;
			entries_q     <= tsrd_pkg::ENTRIES_RST;
			low_q         <= tsrd_pkg::LOW_RST;
			high_q        <= tsrd_pkg::HIGH_RST;
			cand_freq_q   <= '0;
			cand_frames_q <= '0;
			cand_symbol_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					tsrd_pkg::REG_FRAMES:  frames_q  <= cfg_data[tsrd_pkg::FRAMES_W-1:0];
					tsrd_pkg::REG_TOL:     tol_q     <= cfg_data;
					tsrd_pkg::REG_ENTRIES: entries_q <= cfg_data[tsrd_pkg::ENTRIES_W-1:0];
					tsrd_pkg::REG_LOW:     low_q     <= cfg_data;
					tsrd_pkg::REG_HIGH:    high_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept && op == tsrd_pkg::OP_CLEAR) begin
				cand_freq_q   <= '0;
				cand_frames_q <= '0;
				cand_symbol_q <= '0;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				cand_freq_q   <= p_q;
				cand_frames_q <= emit ? tsrd_pkg::FRAMES_W'(1) : new_frames;
				cand_symbol_q <= (emit || !stable_q) ? lut_q : cand_symbol_q;
				if (emit) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_go) begin
			p_q      <= pitch;
			stable_q <= stable;
			fresh_q  <= (cand_freq_q == '0);
		end
		if (state_q == tsrd_pkg::ST_WALK && res.done) begin
			lut_q <= res.symbol;
		end
		if (commit && emit) begin
			symbol_q <= emit_sym;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;

endmodule

[src/tsrd_checker.sv]
module tsrd_checker #(
	parameter int PITCH_BITS = 20
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  op,
	input logic [PITCH_BITS-1:0]       pitch,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [tsrd_pkg::SYM_W-1:0]  symbol
);

	// a stalled output beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol))
		else $error("output beat dropped or changed while stalled");

	// a frame with a pitch starts a table walk
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == tsrd_pkg::OP_FRAME && pitch != '0 |=> !in_ready)
		else $error("input taken during table walk");

	// loads and clears complete in one beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == tsrd_pkg::OP_LOAD || op == tsrd_pkg::OP_CLEAR)
		|=> in_ready)
		else $error("load or clear stalled the input");

	// a new symbol only appears as a frame finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("symbol emitted outside frame completion");

endmodule

bind tone_symbol_run_decoder tsrd_checker #(.PITCH_BITS(PITCH_BITS)) u_tsrd_checker (.*);

[sim/tb_tone_symbol_run_decoder.sv]
class tone_run_tracker #(int TABLE_N = 32, int PITCH_W = 20);
	logic [tsrd_pkg::FRAMES_W-1:0]  frames_needed = tsrd_pkg::FRAMES_RST;
	logic [tsrd_pkg::MARGIN_W-1:0]  tolerance     = tsrd_pkg::TOL_RST;
	logic [tsrd_pkg::ENTRIES_W-1:0] entries_used  = tsrd_pkg::ENTRIES_RST;
	logic [tsrd_pkg::MARGIN_W-1:0]  margin_lo     = tsrd_pkg::LOW_RST;
	logic [tsrd_pkg::MARGIN_W-1:0]  margin_hi     = tsrd_pkg::HIGH_RST;

	logic [PITCH_W-1:0]            cand_freq   = '0;
	logic [tsrd_pkg::FRAMES_W-1:0] cand_frames = '0;
	logic [tsrd_pkg::SYM_W-1:0]    cand_sym    = '0;
	logic [PITCH_W-1:0]            tone_freq [TABLE_N];
	logic [tsrd_pkg::SYM_W-1:0]    tone_sym  [TABLE_N];

	logic [tsrd_pkg::SYM_W-1:0] due_symbols [$];
	int mismatches = 0;

	function int live_entries();
		if (entries_used > TABLE_N) return TABLE_N;
		if (entries_used < 1) return 1;
		return int'(entries_used);
	endfunction

	function void write_reg(logic [tsrd_pkg::CFG_IDX_W-1:0] idx,
			logic [tsrd_pkg::CFG_W-1:0] data);
		case (idx)
			tsrd_pkg::REG_FRAMES:  frames_needed = data[tsrd_pkg::FRAMES_W-1:0];
			tsrd_pkg::REG_TOL:     tolerance = data[tsrd_pkg::MARGIN_W-1:0];
			tsrd_pkg::REG_ENTRIES: entries_used = data[tsrd_pkg::ENTRIES_W-1:0];
			tsrd_pkg::REG_LOW:     margin_lo = data[tsrd_pkg::MARGIN_W-1:0];
			tsrd_pkg::REG_HIGH:    margin_hi = data[tsrd_pkg::MARGIN_W-1:0];
			default: ;
		endcase
	endfunction

	function logic [tsrd_pkg::SYM_W-1:0] match_tone(logic [PITCH_W-1:0] p);
		int n;
		longint pv, lo, hi;
		n = live_entries();
		pv = longint'(p);
		lo = longint'(tone_freq[0]);
		if (pv + longint'(margin_lo) > lo && pv <= lo) return tone_sym[0];
		for (int i = 0; i + 1 < n; i++) begin
			lo = longint'(tone_freq[i]);
			hi = longint'(tone_freq[i + 1]);
			if (lo < pv && pv <= hi) begin
				// nearer tone wins, upper one on a tie
				if (hi - pv > pv - lo) return tone_sym[i];
				return tone_sym[i + 1];
			end
		end
		hi = longint'(tone_freq[n - 1]);
		if (hi < pv && pv < hi + longint'(margin_hi)) return tone_sym[n - 1];
		return '0;
	endfunction

	function void note_beat(logic [1:0] op, logic [PITCH_W-1:0] p,
			logic [tsrd_pkg::INDEX_W-1:0] idx, logic [PITCH_W-1:0] f,
			logic [tsrd_pkg::SYM_W-1:0] s);
		logic [PITCH_W-1:0] diff;
		case (op)
			tsrd_pkg::OP_LOAD: begin
				tone_freq[idx] = f;
				tone_sym[idx] = s;
			end
			tsrd_pkg::OP_CLEAR: begin
				cand_freq = '0;
				cand_frames = '0;
				cand_sym = '0;
			end
			tsrd_pkg::OP_FRAME: begin
				if (p != 0) begin
					if (cand_freq == 0) begin
						cand_freq = p;
						cand_frames = 1;
						cand_sym = match_tone(p);
					end else begin
						diff = (p > cand_freq) ? p - cand_freq : cand_freq - p;
						if (diff < PITCH_W'(tolerance)) begin
							if (cand_frames != tsrd_pkg::FRAMES_MAX)
								cand_frames = cand_frames + 1'b1;
						end else begin
							cand_frames = 1;
							cand_sym = match_tone(p);
						end
						cand_freq = p;
						if (cand_frames == frames_needed) begin
							due_symbols.push_back(cand_sym);
							cand_frames = 1;
							cand_sym = match_tone(p);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function void check_symbol(logic [tsrd_pkg::SYM_W-1:0] got);
		logic [tsrd_pkg::SYM_W-1:0] want;
		if (due_symbols.size() == 0) begin
			$error("symbol: no result expected, got %0d", got);
			mismatches++;
		end else begin
			want = due_symbols.pop_front();
			if (got !== want) begin
				$error("symbol: expected %0d, got %0d", want, got);
				mismatches++;
			end
		end
	endfunction
endclass

module tb_tone_symbol_run_decoder;
	localparam int TABLE_N = 32;
	localparam int PITCH_W = 20;
	localparam int PITCH_TOP = (1 << PITCH_W) - 1;
	localparam int SETTLE = TABLE_N + 8;
	localparam int HOLD_CYCLES = 1000;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int MARK_CLEAR = -1;
	localparam int MARK_SPARE = -2;
	localparam int LAYOUT_SPREAD = 0;
	localparam int LAYOUT_DENSE = 1;
	localparam int LAYOUT_FLOOR = 2;
	localparam int LAYOUT_CEILING = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tsrd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tsrd_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = tsrd_pkg::OP_FRAME;
	logic [PITCH_W-1:0] pitch = '0;
	logic [tsrd_pkg::INDEX_W-1:0] entry_index = '0;
	logic [PITCH_W-1:0] entry_freq = '0;
	logic [tsrd_pkg::SYM_W-1:0] entry_symbol = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [tsrd_pkg::SYM_W-1:0] symbol;

	tone_run_tracker #(TABLE_N, PITCH_W) tracker = new;

	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int gap_pct = 0;
	int beats_sent = 0;

	tone_symbol_run_decoder #(
		.TABLE_DEPTH(TABLE_N),
		.PITCH_BITS(PITCH_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.pitch(pitch),
		.entry_index(entry_index),
		.entry_freq(entry_freq),
		.entry_symbol(entry_symbol),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.symbol(symbol)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) tracker.check_symbol(symbol);
	end

	function automatic int pitch_clamp(input int p);
		if (p < 1) return 1;
		if (p > PITCH_TOP) return PITCH_TOP;
		return p;
	endfunction

	function automatic int pick_pitch();
		int n, k, j, first, last, here;
		n = tracker.live_entries();
		k = $urandom_range(n - 1);
		j = $urandom_range(1);
		here = int'(tracker.tone_freq[k]);
		first = int'(tracker.tone_freq[0]);
		last = int'(tracker.tone_freq[n - 1]);
		case ($urandom_range(6))
			0: return pitch_clamp(here);
			1: return pitch_clamp(here + int'($urandom_range(400)) - 200);
			// midway between neighbours, exact tie when the sum is even
			2: return pitch_clamp((here + int'(tracker.tone_freq[(k + 1) % n]) + j) / 2);
			3: return pitch_clamp(first - int'(tracker.margin_lo) + j);
			4: return pitch_clamp(last + int'(tracker.margin_hi) - j);
			5: return pitch_clamp(last + j);
			default: return pitch_clamp(int'($urandom_range(PITCH_TOP)));
		endcase
	endfunction

	task automatic send_beat(input logic [1:0] b_op, input logic [PITCH_W-1:0] b_pitch,
			input logic [tsrd_pkg::INDEX_W-1:0] b_idx, input logic [PITCH_W-1:0] b_freq,
			input logic [tsrd_pkg::SYM_W-1:0] b_sym);
		if (!quiet && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(19, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= b_op;
		pitch <= b_pitch;
		entry_index <= b_idx;
		entry_freq <= b_freq;
		entry_symbol <= b_sym;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_beat(b_op, b_pitch, b_idx, b_freq, b_sym);
		if (!(b_op == OP_SPARE || (b_op == tsrd_pkg::OP_FRAME && b_pitch == 0))) beats_sent++;
	endtask

	task automatic send_pitch(input int p);
		send_beat(tsrd_pkg::OP_FRAME, PITCH_W'(p), tsrd_pkg::INDEX_W'($urandom()),
			PITCH_W'($urandom()), tsrd_pkg::SYM_W'($urandom()));
	endtask

	task automatic send_op(input logic [1:0] code);
		send_beat(code, PITCH_W'($urandom()), tsrd_pkg::INDEX_W'($urandom()),
			PITCH_W'($urandom()), tsrd_pkg::SYM_W'($urandom()));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.due_symbols.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_setup(input int ftd, input int tol, input int n, input int lo,
			input int hi);
		int vals [5];
		logic [tsrd_pkg::CFG_IDX_W-1:0] idxs [5];
		vals = '{ftd, tol, n, lo, hi};
		idxs = '{tsrd_pkg::REG_FRAMES, tsrd_pkg::REG_TOL, tsrd_pkg::REG_ENTRIES,
			tsrd_pkg::REG_LOW, tsrd_pkg::REG_HIGH};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= tsrd_pkg::CFG_W'(vals[i]);
			@(posedge clk);
			tracker.write_reg(idxs[i], tsrd_pkg::CFG_W'(vals[i]));
		end
		cfg_we <= 1'b0;
	endtask

	task automatic load_table(input int count, input int layout);
		int gaps [TABLE_N];
		int span, f;
		span = 0;
		for (int i = 1; i < count; i++) begin
			gaps[i] = (layout == LAYOUT_DENSE) ? $urandom_range(6, 1) : $urandom_range(28000, 200);
			span += gaps[i];
		end
		case (layout)
			LAYOUT_FLOOR:   f = 0;
			LAYOUT_CEILING: f = PITCH_TOP - span;
			default:        f = $urandom_range(100000, 1);
		endcase
		for (int i = 0; i < count; i++) begin
			if (i > 0) f += gaps[i];
			send_beat(tsrd_pkg::OP_LOAD, PITCH_W'($urandom()), tsrd_pkg::INDEX_W'(i),
				PITCH_W'(f), tsrd_pkg::SYM_W'($urandom()));
		end
	endtask

	task automatic play_phase(input int want);
		int stop_at, base, len, spread, r, k, slot;
		logic [PITCH_W-1:0] f;
		stop_at = beats_sent + want;
		while (beats_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 70) begin
				// run of one tone, jitter kept inside the tolerance
				base = pick_pitch();
				len = $urandom_range(int'(tracker.frames_needed) + 2, 1);
				spread = (tracker.tolerance > 1) ?
					$urandom_range((int'(tracker.tolerance) - 1) / 2) : 0;
				repeat (len) begin
					if ($urandom_range(9) == 0) send_pitch(0);
					k = $urandom_range(2 * spread);
					send_pitch(pitch_clamp(base - spread + k));
				end
			end else if (r < 76) begin
				send_pitch(0);
			end else if (r < 80) begin
				send_op(OP_SPARE);
			end else if (r < 85) begin
				send_op(tsrd_pkg::OP_CLEAR);
			end else if (r < 90) begin
				slot = $urandom_range(TABLE_N - 1);
				f = $urandom_range(1) ? tracker.tone_freq[slot] : PITCH_W'($urandom());
				send_beat(tsrd_pkg::OP_LOAD, PITCH_W'($urandom()), tsrd_pkg::INDEX_W'(slot), f,
					tsrd_pkg::SYM_W'($urandom()));
			end else begin
				send_pitch(pitch_clamp(int'($urandom_range(PITCH_TOP))));
			end
		end
	endtask

	task automatic run_phase(input int ftd, input int tol, input int n, input int lo,
			input int hi, input int layout, input int want, input int gaps);
		settle();
		gap_pct = gaps;
		apply_setup(ftd, tol, n, lo, hi);
		load_table(n, layout);
		play_phase(want);
	endtask

	initial begin : sink
		wait (arst_n === 1'b1);
		forever begin
			if (quiet) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if (hold_req) begin
				// long hold so the block backs up and stalls its input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= 1'b1;
				repeat (($urandom_range(3) == 0) ? $urandom_range(200, 20) : $urandom_range(40, 1))
					@(posedge clk);
				out_ready <= 1'b0;
				repeat ($urandom_range(19, 1)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int opening [23] = '{MARK_SPARE, 0, 16000, 16000, 16303, 16000, 16304, MARK_CLEAR,
			15360, 15361, 15361, 15361, 21600, 21600, 21600, 21600,
			70399, 70400, 70399, 70400, PITCH_TOP, MARK_CLEAR, 16000};
		int steady;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// known ascending table, 100 Hz apart from 1000 Hz
		gap_pct = 0;
		for (int i = 0; i < TABLE_N; i++)
			send_beat(tsrd_pkg::OP_LOAD, PITCH_W'($urandom()), tsrd_pkg::INDEX_W'(i),
				PITCH_W'(16000 + 1600 * i),
				(i == TABLE_N - 1) ? tsrd_pkg::SYM_W'(8'hFF) : tsrd_pkg::SYM_W'(8'h30 + i));

		gap_pct = 20;
		foreach (opening[i]) begin
			if (opening[i] == MARK_CLEAR) send_op(tsrd_pkg::OP_CLEAR);
			else if (opening[i] == MARK_SPARE) send_op(OP_SPARE);
			else send_pitch(opening[i]);
		end

		hold_req = 1'b1;
		run_phase(4, 304, 32, 640, 4800, LAYOUT_SPREAD, 140, 20);
		run_phase(1, 304, 2, 0, 0, LAYOUT_DENSE, 80, 30);
		run_phase(3, 0, 16, 65535, 65535, LAYOUT_FLOOR, 80, 10);
		run_phase(2, 65535, 32, 100, 200, LAYOUT_CEILING, 80, 0);

		// run counter saturation: lower the threshold under a run already past it
		settle();
		gap_pct = 10;
		apply_setup(255, 304, 32, 640, 4800);
		steady = pitch_clamp(int'(tracker.tone_freq[7]));
		send_op(tsrd_pkg::OP_CLEAR);
		repeat (10) send_pitch(steady);
		settle();
		apply_setup(5, 304, 32, 640, 4800);
		repeat (250) send_pitch(steady);
		settle();
		apply_setup(255, 304, 32, 640, 4800);
		repeat (3) send_pitch(steady);

		repeat (4) begin
			run_phase($urandom_range(8, 1),
				($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(3000),
				$urandom_range(32, 2), $urandom_range(65535), $urandom_range(65535),
				$urandom_range(LAYOUT_CEILING), 90, 15 * $urandom_range(2));
		end

		quiet = 1'b1;
		run_phase(4, 500, 32, 640, 4800, LAYOUT_SPREAD, 140, 0);
		settle();

		if (tracker.mismatches == 0 && tracker.due_symbols.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
